// ===== hw/rtl/ptsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsa_pkg: shared types and constants of the per-target stats accumulator
// Field widths, the per-server memory word, the input word and the report row.
// ----------------------------------------------------------------------------
package ptsa_pkg;
	localparam int PktW = 40;
	localparam int ByteW = 48;
	localparam int SumW = 40;
	localparam int SqW = 64;
	localparam int CntW = 32;
	localparam int LatW = 24;
	localparam int LenW = 16;
	localparam int TickW = 24;
	localparam int IdxW = 4;
	localparam int EntryW = PktW + ByteW + SumW + SqW + CntW;

	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic CFG_ACTIVE = 1'b0;
	localparam logic CFG_INTERVAL = 1'b1;

	typedef struct packed {
		logic [PktW-1:0]  pkts;
		logic [ByteW-1:0] bytes;
		logic [SumW-1:0]  sum;
		logic [SqW-1:0]   sqsum;
		logic [CntW-1:0]  cnt;
	} entry_t;

	typedef struct packed {
		logic            func;
		logic [IdxW-1:0] server_index;
		logic [LenW-1:0] packet_length;
		logic [LatW-1:0] latency;
	} in_word_t;

	typedef struct packed {
		logic [IdxW-1:0]  report_server;
		logic [PktW-1:0]  packet_count;
		logic [ByteW-1:0] byte_count;
		logic [LatW-1:0]  latency_mean;
		logic [LatW-1:0]  latency_sdev;
		logic             last_row;
	} out_word_t;
endpackage

// ===== hw/rtl/ptsa_if.sv =====
// ----------------------------------------------------------------------------
// ptsa_if: valid/ready channel
// Carries one word of a generic payload type.
// ----------------------------------------------------------------------------
interface ptsa_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ptsa_ram.sv =====
// ----------------------------------------------------------------------------
// ptsa_ram: generic single-port-write, one-read RAM
// Read data is registered.
// ----------------------------------------------------------------------------
module ptsa_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/ptsa_stat.sv =====
// ----------------------------------------------------------------------------
// ptsa_stat: mean and deviation unit
// Sequential: divides sum and square sum by the sample count (one quotient
// bit per cycle each), then takes an integer square root two bits a cycle.
// ----------------------------------------------------------------------------
module ptsa_stat (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ptsa_pkg::SumW-1:0] sum,
	input  logic [ptsa_pkg::SqW-1:0]  sqsum,
	input  logic [ptsa_pkg::CntW-1:0] cnt,
	output logic                      done,
	output logic [ptsa_pkg::LatW-1:0] mean,
	output logic [ptsa_pkg::LatW-1:0] sd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_SUB = 2'd2;
	localparam logic [1:0] ST_SQRT = 2'd3;

	logic [1:0]  state_q;
	logic [6:0]  step_q;
	logic [63:0] qs_q, qq_q, rs_q, rq_q;
	logic [31:0] d_q;
	logic [63:0] v_q, res_q, bit_q;
	logic [47:0] msq_q;
	logic        zero_q;
	logic [64:0] rs_n, rq_n;
	logic [63:0] mclamp;

	assign rs_n = {rs_q, qs_q[63]};
	assign rq_n = {rq_q, qq_q[63]};
	assign mclamp = (qs_q > 64'hFFFFFF) ? 64'hFFFFFF : qs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						zero_q <= (cnt == '0);
						d_q <= cnt;
						qs_q <= {24'd0, sum};
						qq_q <= sqsum;
						rs_q <= '0;
						rq_q <= '0;
						step_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// Restoring division, both dividends share the divisor.
					if (rs_n >= {33'd0, d_q}) begin
						rs_q <= 64'(rs_n - {33'd0, d_q});
						qs_q <= {qs_q[62:0], 1'b1};
					end else begin
						rs_q <= rs_n[63:0];
						qs_q <= {qs_q[62:0], 1'b0};
					end
					if (rq_n >= {33'd0, d_q}) begin
						rq_q <= 64'(rq_n - {33'd0, d_q});
						qq_q <= {qq_q[62:0], 1'b1};
					end else begin
						rq_q <= rq_n[63:0];
						qq_q <= {qq_q[62:0], 1'b0};
					end
					step_q <= 7'(step_q + 7'd1);
					if (step_q == 7'd63) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					mean <= mclamp[23:0];
					msq_q <= mclamp[23:0] * mclamp[23:0];
					state_q <= ST_SQRT;
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
					step_q <= '0;
				end
				ST_SQRT: begin
					if (step_q == 7'd0) begin
						v_q <= (qq_q > {16'd0, msq_q}) ? qq_q - {16'd0, msq_q} : '0;
						step_q <= 7'd1;
					end else if (bit_q == '0) begin
						sd <= zero_q ? '0 : ((res_q > 64'hFFFFFF) ? 24'hFFFFFF : res_q[23:0]);
						if (zero_q) begin
							mean <= '0;
						end
						done <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (v_q >= res_q + bit_q) begin
							v_q <= v_q - (res_q + bit_q);
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE) else $error("done outside idle");
	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_q) |=> (mean == '0 && sd == '0)) else $error("empty nonzero");
endmodule

// ===== hw/rtl/per_target_stats_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// per_target_stats_accumulator_top: per-server counters with periodic reports
// Packet words update one server entry in RAM; report ticks sweep the RAM.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   in      | in  | func, server_index, packet_length, latency
//   out     | out | report_server, packet_count, byte_count, latency_mean,
//           |     | latency_sdev, last_row
//   cfg     | in  | cfg_we, cfg_index, cfg_data (24 bits)
// A packet word passes through a RAM read, modify and write back.
// A tick that does not end the interval only advances the tick count.
// A report row passes through a RAM read, the bit-serial divider and
// square root, and the load of the one-word output register.
// A row still waiting in that register holds the sweep; no word is taken
// until the report ends. Reset clears control state; a sweep after reset
// clears the RAM, during which no word is taken.
module per_target_stats_accumulator_top #(
	parameter int MAX_SERVERS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ptsa_if.sink                       in,
	ptsa_if.source                     out,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ptsa_pkg::TickW-1:0] cfg_data
);
	localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int NW = $clog2(MAX_SERVERS + 1);
	localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_UPD = 3'd2,
		S_WB = 3'd3, S_RD = 3'd4, S_CALC = 3'd5, S_EMIT = 3'd6;

	ptsa_pkg::in_word_t  iw;
	ptsa_pkg::in_word_t  w_q;
	ptsa_pkg::entry_t    rd, wd, e_q;
	logic [2:0]          state_q;
	logic [AW-1:0]       ptr_q, waddr, raddr;
	logic                we, st_start, st_done;
	logic                emit, is_last;
	logic [4:0]          active_q;
	logic [23:0]         interval_q, ticks_q, t_next;
	logic [NW-1:0]       n;
	logic [23:0]         mean, sd;
	logic [64:0]         lsq;
	logic [64:0]         sq_sum;

	assign iw = in.data;
	assign n = (32'(active_q) > 32'(MAX_SERVERS)) ? NW'(MAX_SERVERS) : NW'(active_q);
	assign t_next = (ticks_q == 24'hFFFFFF) ? ticks_q : 24'(ticks_q + 24'd1);
	assign in.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			interval_q <= 24'd100;
		end else if (cfg_we) begin
			if (cfg_index == ptsa_pkg::CFG_ACTIVE) begin
				active_q <= cfg_data[4:0];
			end else begin
				interval_q <= cfg_data;
			end
		end
	end

	ptsa_ram #(.Width(ptsa_pkg::EntryW), .Depth(1 << AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wd), .raddr(raddr), .rdata(rd)
	);

	ptsa_stat u_stat (
		.clk(clk), .arst_n(arst_n), .start(st_start), .sum(rd.sum),
		.sqsum(rd.sqsum), .cnt(rd.cnt), .done(st_done), .mean(mean), .sd(sd)
	);

	assign raddr = (state_q == S_IDLE) ? AW'(iw.server_index) : ptr_q;
	assign lsq = {41'd0, w_q.latency} * {41'd0, w_q.latency};
	assign sq_sum = {1'b0, rd.sqsum} + lsq;

	// A row moves into the output register when that register is free or
	// its word is being taken in the same cycle.
	assign emit = (state_q == S_EMIT) && (!out.valid || out.ready);
	assign is_last = (NW'(ptr_q) + NW'(1) == n);

	always_comb begin
		we = 1'b0;
		waddr = ptr_q;
		wd = '0;
		case (state_q)
			S_CLR: we = 1'b1;
			S_WB: begin
				we = 1'b1;
				waddr = AW'(w_q.server_index);
				wd = e_q;
			end
			S_EMIT: we = emit;
			default: we = 1'b0;
		endcase
	end

	assign st_start = (state_q == S_CALC) && !st_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ptr_q <= '0;
			ticks_q <= '0;
			out.valid <= 1'b0;
		end else begin
			if (emit) begin
				out.valid <= 1'b1;
			end else if (out.ready) begin
				out.valid <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					ptr_q <= AW'(ptr_q + 1'b1);
					if ({1'b0, ptr_q} == (AW+1)'(MAX_SERVERS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in.valid) begin
						w_q <= iw;
						if (iw.func == ptsa_pkg::FUNC_PACKET) begin
							if (32'(iw.server_index) < 32'(n)) begin
								state_q <= S_UPD;
							end
						end else if (t_next < interval_q) begin
							ticks_q <= t_next;
						end else begin
							ticks_q <= '0;
							ptr_q <= '0;
							if (n != '0) begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_UPD: begin
					e_q.pkts <= (rd.pkts == '1) ? rd.pkts : rd.pkts + 1'b1;
					e_q.bytes <= (rd.bytes > ~48'(w_q.packet_length)) ? '1
						: rd.bytes + 48'(w_q.packet_length);
					if (w_q.latency != '0) begin
						e_q.sum <= (rd.sum > ~40'(w_q.latency)) ? '1
							: rd.sum + 40'(w_q.latency);
						e_q.sqsum <= sq_sum[64] ? '1 : sq_sum[63:0];
						e_q.cnt <= (rd.cnt == '1) ? rd.cnt : rd.cnt + 1'b1;
					end else begin
						e_q.sum <= rd.sum;
						e_q.sqsum <= rd.sqsum;
						e_q.cnt <= rd.cnt;
					end
					state_q <= S_WB;
				end
				S_WB: state_q <= S_IDLE;
				S_RD: state_q <= S_CALC;
				S_CALC: begin
					if (st_start) begin
						e_q <= rd;
					end
					if (st_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// The entry is cleared in the cycle its row is loaded.
					if (emit) begin
						out.data.report_server <= ptsa_pkg::IdxW'(ptr_q);
						out.data.packet_count <= e_q.pkts;
						out.data.byte_count <= e_q.bytes;
						out.data.latency_mean <= mean;
						out.data.latency_sdev <= sd;
						out.data.last_row <= is_last;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= AW'(ptr_q + 1'b1);
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && !out.ready) |=> (out.valid && $stable(out.data)))
		else $error("output word changed while waiting");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (32'(ptr_q) < 32'(n)))
		else $error("report pointer out of range");
	a_stat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_done |-> (state_q == S_CALC))
		else $error("statistics done outside a report");
endmodule

// ===== tb/per_target_stats_accumulator_top_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_target_stats_accumulator_top_monitor: report row predictor and compare
// Watches the input, output and register ports and keeps its own copy of the
// per-server counters. Every accepted output word is compared, field by field,
// with the oldest predicted report row.
// ----------------------------------------------------------------------------
module per_target_stats_accumulator_top_monitor #(
	parameter int MAX_SERVERS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  ptsa_pkg::in_word_t         in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  ptsa_pkg::out_word_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ptsa_pkg::TickW-1:0] cfg_data,
	output int                         fail_count,
	output int                         rows_pending
);
	localparam logic [ptsa_pkg::PktW-1:0]  PKT_MAX = '1;
	localparam logic [ptsa_pkg::ByteW-1:0] BYTE_MAX = '1;
	localparam logic [ptsa_pkg::SumW-1:0]  SUM_MAX = '1;
	localparam logic [ptsa_pkg::SqW-1:0]   SQ_MAX = '1;
	localparam logic [ptsa_pkg::CntW-1:0]  CNT_MAX = '1;
	localparam logic [ptsa_pkg::LatW-1:0]  LAT_MAX = '1;
	localparam logic [ptsa_pkg::TickW-1:0] TICK_MAX = '1;

	logic [4:0]                 active_servers;
	logic [ptsa_pkg::TickW-1:0] report_interval;
	logic [ptsa_pkg::TickW-1:0] tick_count;
	ptsa_pkg::entry_t           server_stats [MAX_SERVERS];
	ptsa_pkg::out_word_t        expected_rows [$];

	assign rows_pending = expected_rows.size();

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Applies one accepted word to the counters and queues any report rows.
	task automatic apply_record(input ptsa_pkg::in_word_t w);
		int                         n;
		logic [ptsa_pkg::TickW-1:0] t;
		logic [63:0]                mean;
		logic [63:0]                msq;
		logic [63:0]                sq;
		logic [63:0]                sd;
		logic [64:0]                wide;
		ptsa_pkg::out_word_t        row;
		ptsa_pkg::entry_t           e;
		n = (active_servers > MAX_SERVERS) ? MAX_SERVERS : int'(active_servers);
		if (w.func == ptsa_pkg::FUNC_PACKET) begin
			if (int'(w.server_index) < n) begin
				e = server_stats[w.server_index];
				e.pkts = (e.pkts == PKT_MAX) ? PKT_MAX : e.pkts + 1'b1;
				wide = 65'(e.bytes) + 65'(w.packet_length);
				e.bytes = (wide >= 65'(BYTE_MAX)) ? BYTE_MAX : wide[ptsa_pkg::ByteW-1:0];
				if (w.latency != 0) begin
					wide = 65'(e.sum) + 65'(w.latency);
					e.sum = (wide >= 65'(SUM_MAX)) ? SUM_MAX : wide[ptsa_pkg::SumW-1:0];
					wide = 65'(e.sqsum) + 65'(64'(w.latency) * 64'(w.latency));
					e.sqsum = (wide >= 65'(SQ_MAX)) ? SQ_MAX : wide[ptsa_pkg::SqW-1:0];
					e.cnt = (e.cnt == CNT_MAX) ? CNT_MAX : e.cnt + 1'b1;
				end
				server_stats[w.server_index] = e;
			end
			return;
		end
		t = (tick_count < TICK_MAX) ? tick_count + 1'b1 : TICK_MAX;
		if (t < report_interval) begin
			tick_count = t;
			return;
		end
		tick_count = '0;
		for (int i = 0; i < n; i++) begin
			e = server_stats[i];
			mean = '0;
			sd = '0;
			if (e.cnt != 0) begin
				mean = 64'(e.sum) / 64'(e.cnt);
				if (mean > 64'(LAT_MAX))
					mean = 64'(LAT_MAX);
				msq = mean * mean;
				sq = e.sqsum / 64'(e.cnt);
				sd = (sq > msq) ? int_sqrt(sq - msq) : '0;
				if (sd > 64'(LAT_MAX))
					sd = 64'(LAT_MAX);
			end
			row.report_server = ptsa_pkg::IdxW'(i);
			row.packet_count = e.pkts;
			row.byte_count = e.bytes;
			row.latency_mean = mean[ptsa_pkg::LatW-1:0];
			row.latency_sdev = sd[ptsa_pkg::LatW-1:0];
			row.last_row = (i + 1 == n);
			expected_rows.push_back(row);
			server_stats[i] = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ptsa_pkg::out_word_t want;
		if (!arst_n) begin
			active_servers = '0;
			report_interval = ptsa_pkg::TickW'(100);
			tick_count = '0;
			for (int i = 0; i < MAX_SERVERS; i++)
				server_stats[i] = '0;
			expected_rows.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ptsa_pkg::CFG_ACTIVE)
					active_servers = cfg_data[4:0];
				else
					report_interval = cfg_data;
			end
			if (in_valid && in_ready)
				apply_record(in_data);
			if (out_valid && out_ready) begin
				if (expected_rows.size() == 0) begin
					$error("unexpected report word for server %0d", out_data.report_server);
					fail_count++;
				end else begin
					want = expected_rows.pop_front();
					if (out_data.report_server !== want.report_server) begin
						$error("report_server: expected %0d, got %0d",
							want.report_server, out_data.report_server);
						fail_count++;
					end
					if (out_data.packet_count !== want.packet_count) begin
						$error("packet_count: expected %0d, got %0d",
							want.packet_count, out_data.packet_count);
						fail_count++;
					end
					if (out_data.byte_count !== want.byte_count) begin
						$error("byte_count: expected %0d, got %0d",
							want.byte_count, out_data.byte_count);
						fail_count++;
					end
					if (out_data.latency_mean !== want.latency_mean) begin
						$error("latency_mean: expected %0d, got %0d",
							want.latency_mean, out_data.latency_mean);
						fail_count++;
					end
					if (out_data.latency_sdev !== want.latency_sdev) begin
						$error("latency_sdev: expected %0d, got %0d",
							want.latency_sdev, out_data.latency_sdev);
						fail_count++;
					end
					if (out_data.last_row !== want.last_row) begin
						$error("last_row: expected %0d, got %0d",
							want.last_row, out_data.last_row);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/per_target_stats_accumulator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_target_stats_accumulator_top_test: stimulus and verdict
// Drives packet and tick words through several register settings and idling
// patterns; the monitor beside the block predicts and checks report rows.
// ----------------------------------------------------------------------------
module per_target_stats_accumulator_top_test;
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  SETTLE = 300;
	localparam int  PHASES = 7;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic                       cfg_index;
	logic [ptsa_pkg::TickW-1:0] cfg_data;
	int                         fail_count;
	int                         rows_pending;
	int                         cycle_count = 0;
	int                         idle_pct;
	int                         stall_pct;

	ptsa_if #(.payload_t(ptsa_pkg::in_word_t))  in_ch ();
	ptsa_if #(.payload_t(ptsa_pkg::out_word_t)) out_ch ();

	per_target_stats_accumulator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in_ch),
		.out       (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	per_target_stats_accumulator_top_monitor u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_data      (in_ch.data),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_data     (out_ch.data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.rows_pending (rows_pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("per_target_stats_accumulator_top_test failed");
			$finish;
		end
	end

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	task automatic write_reg(input logic idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ptsa_pkg::TickW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Valid stays high between back-to-back words; it drops only for a gap.
	task automatic send_word(input ptsa_pkg::in_word_t w);
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_fields(input logic f, input int idx, input int len, input int lat);
		ptsa_pkg::in_word_t w;
		w.func = f;
		w.server_index = ptsa_pkg::IdxW'(idx);
		w.packet_length = ptsa_pkg::LenW'(len);
		w.latency = ptsa_pkg::LatW'(lat);
		send_word(w);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic ptsa_pkg::in_word_t random_word();
		ptsa_pkg::in_word_t w;
		int                 pick;
		w.func = ($urandom_range(99) < 25) ? ptsa_pkg::FUNC_TICK : ptsa_pkg::FUNC_PACKET;
		w.server_index = ptsa_pkg::IdxW'($urandom_range(15));
		pick = $urandom_range(9);
		w.packet_length = (pick == 0) ? '1 : (pick == 1) ? '0 : ptsa_pkg::LenW'($urandom);
		pick = $urandom_range(9);
		w.latency = (pick < 2) ? '0 : (pick == 2) ? '1 : ptsa_pkg::LatW'($urandom);
		return w;
	endfunction

	initial begin
		int actives   [PHASES] = '{16, 5, 31, 0, 1, 16, 12};
		int intervals [PHASES] = '{3, 0, 2, 1, 16777215, 4, 1};
		int idles     [PHASES] = '{0, 67, 0, 33, 0, 67, 33};
		int stalls    [PHASES] = '{0, 0, 67, 33, 0, 67, 0};
		idle_pct = 0;
		stall_pct = 0;
		cfg_we = 1'b0;
		cfg_index = ptsa_pkg::CFG_ACTIVE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (20) @(posedge clk);

		// Directed part: field extremes, an ignored server, a tick per report.
		write_reg(ptsa_pkg::CFG_ACTIVE, 16);
		write_reg(ptsa_pkg::CFG_INTERVAL, 1);
		send_fields(ptsa_pkg::FUNC_PACKET, 0, 0, 0);
		send_fields(ptsa_pkg::FUNC_PACKET, 0, 65535, 16777215);
		send_fields(ptsa_pkg::FUNC_PACKET, 0, 1, 1);
		send_fields(ptsa_pkg::FUNC_PACKET, 15, 65535, 16777215);
		send_fields(ptsa_pkg::FUNC_PACKET, 15, 65535, 16777215);
		send_fields(ptsa_pkg::FUNC_PACKET, 7, 100, 256);
		send_fields(ptsa_pkg::FUNC_PACKET, 7, 200, 768);
		send_fields(ptsa_pkg::FUNC_TICK, 15, 65535, 16777215);
		drain();
		write_reg(ptsa_pkg::CFG_ACTIVE, 3);
		send_fields(ptsa_pkg::FUNC_PACKET, 9, 500, 1000);
		send_fields(ptsa_pkg::FUNC_PACKET, 2, 40, 0);
		send_fields(ptsa_pkg::FUNC_TICK, 0, 0, 0);
		drain();
		write_reg(ptsa_pkg::CFG_ACTIVE, 16);
		send_fields(ptsa_pkg::FUNC_TICK, 0, 0, 0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(ptsa_pkg::CFG_ACTIVE, actives[p]);
			write_reg(ptsa_pkg::CFG_INTERVAL, intervals[p]);
			idle_pct = idles[p];
			stall_pct = stalls[p];
			for (int k = 0; k < 34; k++)
				send_word(random_word());
			drain();
		end

		if (fail_count == 0)
			$display("per_target_stats_accumulator_top_test passed");
		else
			$display("per_target_stats_accumulator_top_test failed");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/ptsa_pkg.sv
hw/rtl/ptsa_if.sv
hw/rtl/ptsa_ram.sv
hw/rtl/ptsa_stat.sv
hw/rtl/per_target_stats_accumulator_top.sv
tb/per_target_stats_accumulator_top_monitor.sv
tb/per_target_stats_accumulator_top_test.sv
